[rtl/pti_pkg.sv]
`default_nettype none

package pti_pkg;

	// Tree geometry
	localparam int NODE_COUNT    = 4096;
	localparam int ALPHABET_SIZE = 26;
	localparam int NODE_W        = $clog2(NODE_COUNT);
	localparam int FREE_W        = NODE_W + 1;
	localparam int LIDX_W        = $clog2(ALPHABET_SIZE);

	// Item field widths
	localparam int REQ_W    = 2;
	localparam int LETTER_W = 5;
	localparam int TDATA_W  = 8;

	localparam logic [NODE_W-1:0] ROOT_NODE = NODE_W'(1);
	localparam logic [FREE_W-1:0] FIRST_FREE = FREE_W'(2);

	// Request types
	localparam logic [REQ_W-1:0] MODE_INSERT = 2'd0;
	localparam logic [REQ_W-1:0] MODE_SEARCH = 2'd1;
	localparam logic [REQ_W-1:0] MODE_PREFIX = 2'd2;

	// One node: child index per letter plus the word-end mark
	typedef struct packed {
		logic                                  end_mark;
		logic [ALPHABET_SIZE-1:0][NODE_W-1:0]  kids;
	} row_t;

	// Controller to datapath
	typedef struct packed {
		logic clr_root;
		logic accept;
		logic advance;
		logic alloc;
		logic miss;
		logic fetch;
		logic new_row;
		logic finish;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic take;
		logic child_zero;
		logic can_alloc;
		logic last;
		logic out_free;
	} dp_stat_t;

endpackage

`default_nettype wire

[rtl/prefix_tree_insert_lookup.sv]
// Sequence: each letter is accepted with a read of its current row, then looked up; a letter
// that adds a node also clears the new row; a word's last letter over an existing child
// re-reads the final node for its word-end mark. A word end waits for a free output slot.
// Flow: one letter at a time; the next is taken only once the last one is done.
// Reset: asynchronous, active low; the first cycle after reset clears the root row,
// during which no transfer is taken.
`default_nettype none

module prefix_tree_insert_lookup
	import pti_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [TDATA_W-1:0] s_tdata,  // [4:0] letter, rest zero
	input  wire logic [REQ_W-1:0]   s_tuser,  // [1:0] req_type
	input  wire logic               s_tlast,
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic [TDATA_W-1:0]      m_tdata   // [0] hit, [1] status, rest zero
);

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     hit;
	logic     status;

	// Sequencer
	pti_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Node table and walk registers
	pti_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.req_type    (s_tuser),
		.letter      (s_tdata[LETTER_W-1:0]),
		.last_letter (s_tlast),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.hit         (hit),
		.status      (status)
	);

	assign m_tdata = {(TDATA_W-2)'(0), status, hit};

endmodule

`default_nettype wire

[rtl/pti_ctrl.sv]
`default_nettype none

module pti_ctrl
	import pti_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     s_tvalid,
	output logic          s_tready,
	input  wire dp_stat_t stat,
	output dp_cmd_t       cmd
);

	localparam logic [2:0] ST_CLR    = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_LOOK   = 3'd2;
	localparam logic [2:0] ST_NEWROW = 3'd3;
	localparam logic [2:0] ST_FREAD  = 3'd4;
	localparam logic [2:0] ST_FIN    = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign s_tready = (state_q == ST_IDLE);

	// Next state and datapath commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_CLR: begin
				cmd.clr_root = 1'b1;
				state_d      = ST_IDLE;
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					state_d    = ST_LOOK;
				end
			end
			ST_LOOK: begin
				// a word end waits here until the output slot is free
				if (!(stat.last && !stat.out_free)) begin
					if (stat.take && !stat.child_zero) begin
						cmd.advance = 1'b1;
						state_d     = stat.last ? ST_FREAD : ST_IDLE;
					end else if (stat.take && stat.can_alloc) begin
						cmd.alloc = 1'b1;
						state_d   = ST_NEWROW;
					end else begin
						cmd.miss   = stat.take;
						cmd.finish = stat.last;
						state_d    = ST_IDLE;
					end
				end
			end
			ST_NEWROW: begin
				if (!(stat.last && !stat.out_free)) begin
					cmd.new_row = 1'b1;
					cmd.finish  = stat.last;
					state_d     = ST_IDLE;
				end
			end
			ST_FREAD: begin
				cmd.fetch = 1'b1;
				state_d   = ST_FIN;
			end
			ST_FIN: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

[rtl/pti_dp.sv]
`default_nettype none

module pti_dp
	import pti_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire dp_cmd_t             cmd,
	output dp_stat_t                 stat,
	input  wire logic [REQ_W-1:0]    req_type,
	input  wire logic [LETTER_W-1:0] letter,
	input  wire logic                last_letter,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic                     hit,
	output logic                     status
);

	// Node table: one row per node
	row_t mem [NODE_COUNT];
	row_t rd_q;

	logic [NODE_W-1:0]   cur_q;
	logic [FREE_W-1:0]   free_q;
	logic                miss_q;
	logic                in_word_q;
	logic [REQ_W-1:0]    mode_q;
	logic [LETTER_W-1:0] letter_q;
	logic                last_q;
	logic                take_q;
	logic                out_valid_q;
	logic                hit_q;
	logic                status_q;

	logic                take_in;
	logic                rd_en;
	logic [NODE_W-1:0]   rd_addr;
	logic                wr_en;
	logic [NODE_W-1:0]   wr_addr;
	row_t                wr_row;
	logic [NODE_W-1:0]   child;
	logic [LIDX_W-1:0]   lidx;
	logic                is_ins;
	logic                is_pre;
	logic                miss_f;
	logic                empty;
	logic                set_end;
	logic                hit_d;
	logic                status_d;

	// Letter lookup on the row just read
	assign lidx  = letter_q[LIDX_W-1:0];
	assign child = rd_q.kids[lidx];

	assign take_in = (in_word_q ? !miss_q : 1'b1) &&
		(letter < LETTER_W'(ALPHABET_SIZE));

	assign stat.take       = take_q;
	assign stat.child_zero = (child == '0);
	assign stat.can_alloc  = (mode_q == MODE_INSERT) && (free_q < FREE_W'(NODE_COUNT));
	assign stat.last       = last_q;
	assign stat.out_free   = !out_valid_q || out_ready;

	// Word-end result
	assign is_ins   = (mode_q == MODE_INSERT);
	assign is_pre   = (mode_q == MODE_PREFIX);
	assign miss_f   = miss_q || cmd.miss;
	assign empty    = (cur_q == ROOT_NODE) && !miss_f;
	assign set_end  = is_ins && !miss_f && !empty;
	assign hit_d    = !empty && !miss_f && (is_ins || is_pre || rd_q.end_mark);
	assign status_d = !empty && is_ins && miss_f;

	// Read port
	assign rd_en   = cmd.accept || cmd.fetch;
	assign rd_addr = (cmd.accept && !in_word_q) ? ROOT_NODE : cur_q;

	// Write port
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cur_q;
		wr_row  = rd_q;
		if (cmd.clr_root) begin
			wr_en   = 1'b1;
			wr_addr = ROOT_NODE;
			wr_row  = '0;
		end else if (cmd.alloc) begin
			wr_en             = 1'b1;
			wr_row.kids[lidx] = free_q[NODE_W-1:0];
		end else if (cmd.new_row) begin
			// fresh node starts with no children
			wr_en           = 1'b1;
			wr_row          = '0;
			wr_row.end_mark = cmd.finish && set_end;
		end else if (cmd.finish && set_end) begin
			wr_en           = 1'b1;
			wr_row.end_mark = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_row;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// Item payload
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			letter_q <= letter;
		end
		if (cmd.finish) begin
			hit_q    <= hit_d;
			status_q <= status_d;
		end
	end

	// Walk state and output slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q       <= ROOT_NODE;
			free_q      <= FIRST_FREE;
			miss_q      <= 1'b0;
			in_word_q   <= 1'b0;
			mode_q      <= MODE_INSERT;
			last_q      <= 1'b0;
			take_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				last_q <= last_letter;
				take_q <= take_in;
				if (!in_word_q) begin
					mode_q    <= req_type;
					cur_q     <= ROOT_NODE;
					miss_q    <= 1'b0;
					in_word_q <= 1'b1;
				end
			end
			if (cmd.advance) begin
				cur_q <= child;
			end
			if (cmd.alloc) begin
				cur_q  <= free_q[NODE_W-1:0];
				free_q <= free_q + FREE_W'(1);
			end
			if (cmd.miss) begin
				miss_q <= 1'b1;
			end
			if (cmd.finish) begin
				in_word_q   <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign hit       = hit_q;
	assign status    = status_q;

	// Free pointer stays between the first free node and one past the last table row
	a_free_range: assert property (@(posedge clk) disable iff (!arst_n)
		(free_q >= FIRST_FREE) && (free_q <= FREE_W'(NODE_COUNT)))
		else $error("free node pointer out of range");

	// Current node is always an allocated node
	a_cur_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, cur_q} < free_q)
		else $error("current node beyond allocated nodes");

	// Only inserts grow the tree
	a_alloc_ins: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.alloc |-> (mode_q == MODE_INSERT) && take_q)
		else $error("node allocated outside an insert");

	// Finishing a word closes it and raises the result
	a_finish: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> !in_word_q && out_valid_q)
		else $error("word end not closed");

	// A result is never overwritten while still waiting
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!out_valid_q || out_ready))
		else $error("result overwritten");

endmodule

`default_nettype wire

[sim/prefix_tree_insert_lookup_test.sv]
`timescale 1ns / 100ps

module prefix_tree_insert_lookup_test;
	import pti_pkg::*;

	// Request type with no meaning of its own; the block handles it as a search
	localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;
	localparam int HOLD_CYCLES = 500;
	localparam int LONG_WORD   = 24;

	typedef struct packed {
		logic status;
		logic hit;
	} word_result_t;

	// Mirror of the prefix tree plus the queue of word results still to come out
	class word_lookup_board;
		bit [NODE_W-1:0] kids [NODE_COUNT*ALPHABET_SIZE];
		bit              word_ends [NODE_COUNT];
		logic [FREE_W-1:0] free_node;
		logic [NODE_W-1:0] cursor;
		logic [REQ_W-1:0]  mode;
		bit                lost;
		bit                in_word;
		word_result_t      pending_word_results [$];
		int                errors;

		function new();
			free_node = FIRST_FREE;
			cursor    = ROOT_NODE;
			mode      = MODE_INSERT;
			lost      = 1'b0;
			in_word   = 1'b0;
			errors    = 0;
		endfunction

		// One accepted letter transfer; a word's last letter queues its result
		function void note_letter(logic [REQ_W-1:0] rq, logic [LETTER_W-1:0] lt, logic lst);
			int           slot;
			bit [NODE_W-1:0] kid;
			word_result_t res;
			if (!in_word) begin
				mode    = rq;
				cursor  = ROOT_NODE;
				lost    = 1'b0;
				in_word = 1'b1;
			end
			// out-of-range letters leave the path where it is
			if (!lost && int'(lt) < ALPHABET_SIZE) begin
				slot = int'(cursor) * ALPHABET_SIZE + int'(lt);
				kid  = kids[slot];
				if (kid == '0) begin
					if (mode != MODE_INSERT || int'(free_node) >= NODE_COUNT) begin
						lost = 1'b1;
					end else begin
						kid         = free_node[NODE_W-1:0];
						kids[slot]  = kid;
						free_node   = free_node + 1'b1;
					end
				end
				if (!lost)
					cursor = kid;
			end
			if (!lst)
				return;
			in_word = 1'b0;
			res     = '0;
			// a word with no letter taken reports nothing found
			if (!(cursor == ROOT_NODE && !lost)) begin
				case (mode)
					MODE_INSERT: begin
						if (lost) begin
							res.status = 1'b1;
						end else begin
							word_ends[cursor] = 1'b1;
							res.hit           = 1'b1;
						end
					end
					MODE_PREFIX: res.hit = !lost;
					default:     res.hit = !lost && word_ends[cursor];
				endcase
			end
			pending_word_results.push_back(res);
		endfunction

		// One accepted result transfer against the oldest queued word result
		function void check_word_result(logic [TDATA_W-1:0] data);
			word_result_t want;
			if (pending_word_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual hit=%0b status=%0b",
					$time, data[0], data[1]);
				errors++;
				return;
			end
			want = pending_word_results.pop_front();
			if (data[0] !== want.hit) begin
				$display("%0t: hit mismatch, expected %0b, actual %0b", $time, want.hit, data[0]);
				errors++;
			end
			if (data[1] !== want.status) begin
				$display("%0t: status mismatch, expected %0b, actual %0b",
					$time, want.status, data[1]);
				errors++;
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [TDATA_W-1:0] s_tdata = '0;
	logic [REQ_W-1:0]   s_tuser = '0;
	logic               s_tlast = 1'b0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [TDATA_W-1:0] m_tdata;

	int send_idle = 0;
	int recv_idle = 0;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;
	int letters_sent = 0;

	word_lookup_board board = new();

	prefix_tree_insert_lookup uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #6 clk = ~clk;

	// Run limit
	initial begin
		#6_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// Result side: random stalls, one long hold-off when asked
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	// Result monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_word_result(m_tdata);
	end

	// Offer one letter, wait for its transfer, then update the mirror
	task automatic send_letter(input logic [REQ_W-1:0] rq, input logic [LETTER_W-1:0] lt,
			input logic lst);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= TDATA_W'(lt);
		s_tuser  <= rq;
		s_tlast  <= lst;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		board.note_letter(rq, lt, lst);
		letters_sent++;
	endtask

	// Directed word: letters packed first-letter-highest, 5 bits each
	task automatic send_word(input logic [REQ_W-1:0] rq, input int len, input logic [39:0] lts);
		for (int i = 0; i < len; i++)
			send_letter(rq, lts[5*(len-1-i) +: 5], i == len - 1);
	endtask

	task automatic send_long_insert();
		for (int i = 0; i < LONG_WORD; i++)
			send_letter(MODE_INSERT, LETTER_W'($urandom_range(ALPHABET_SIZE - 1)),
				i == LONG_WORD - 1);
	endtask

	// Mostly short words over a few letters so lookups hit, some wide words, some noise
	task automatic send_random_word();
		int              pick;
		int              kind;
		int              len;
		int              top;
		logic [REQ_W-1:0] rq;
		logic [LETTER_W-1:0] lt;
		pick = $urandom_range(99);
		kind = $urandom_range(99);
		if (pick < 35)
			rq = MODE_INSERT;
		else if (pick < 65)
			rq = MODE_SEARCH;
		else if (pick < 90)
			rq = MODE_PREFIX;
		else
			rq = REQ_SPARE;
		if (kind < 70) begin
			len = $urandom_range(4, 1);
			top = 3;
		end else if (kind < 90) begin
			len = $urandom_range(8, 1);
			top = ALPHABET_SIZE - 1;
		end else begin
			len = $urandom_range(3, 1);
			top = 31;
		end
		for (int i = 0; i < len; i++) begin
			lt = LETTER_W'($urandom_range(top));
			// type is only sampled on the first letter; later ones carry junk
			send_letter(i == 0 ? rq : REQ_W'($urandom_range(3)), lt, i == len - 1);
		end
	endtask

	// Stimulus
	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// sender idles lightly, receiver heavily
		send_idle = 33;
		recv_idle <= 86;

		// directed words: both letter extremes, all request types,
		// ignored letters, empty words, missing paths
		send_word(MODE_INSERT, 1, 40'({5'd0}));
		send_word(MODE_INSERT, 2, 40'({5'd25, 5'd25}));
		send_word(MODE_SEARCH, 1, 40'({5'd0}));
		send_word(MODE_SEARCH, 1, 40'({5'd25}));
		send_word(MODE_PREFIX, 1, 40'({5'd25}));
		send_word(MODE_SEARCH, 2, 40'({5'd25, 5'd25}));
		send_word(MODE_SEARCH, 1, 40'({5'd1}));
		send_word(MODE_INSERT, 3, 40'({5'd0, 5'd31, 5'd1}));
		send_word(REQ_SPARE, 2, 40'({5'd0, 5'd1}));
		send_word(MODE_PREFIX, 3, 40'({5'd0, 5'd26, 5'd1}));
		send_word(MODE_SEARCH, 1, 40'({5'd30}));
		send_word(MODE_INSERT, 2, 40'({5'd27, 5'd28}));
		send_word(MODE_PREFIX, 2, 40'({5'd2, 5'd3}));

		while (letters_sent < 250)
			send_random_word();

		// sender idles heavily, receiver lightly
		send_idle = 86;
		recv_idle <= 33;
		while (letters_sent < 480)
			send_random_word();

		// no idling; receiver holds off so the block backs up into its input
		send_idle = 0;
		recv_idle <= 0;
		hold_req <= 1'b1;
		repeat (60)
			send_random_word();

		// a couple of deep inserts, then fill up to the item budget
		repeat (2)
			send_long_insert();
		while (letters_sent < 750)
			send_random_word();
		s_tvalid <= 1'b0;

		while (board.pending_word_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (board.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

[sim.f]
rtl/pti_pkg.sv
rtl/pti_ctrl.sv
rtl/pti_dp.sv
rtl/prefix_tree_insert_lookup.sv
sim/prefix_tree_insert_lookup_test.sv
